/* hw/rtl/ipv4p_pkg.sv */
package ipv4p_pkg;

  // Character codes and limits
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [31:0] OCTET_MAX = 32'd255;
  localparam int unsigned NUM_STORED = 3;
  localparam logic [1:0] POS_LAST = 2'd3;

  // One input transaction
  typedef struct packed {
    logic [7:0] character;
    logic       has_character;
    logic       last;
  } ipv4p_item_t;

  // One result transaction
  typedef struct packed {
    logic [31:0] address;
    logic        ok;
  } ipv4p_result_t;

endpackage

/* hw/rtl/ipv4p_in_if.sv */
interface ipv4p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       has_character;
  logic       last;

  modport source (output valid, output character, output has_character, output last,
                  input ready);
  modport sink (input valid, input character, input has_character, input last,
                output ready);
endinterface

/* hw/rtl/ipv4p_out_if.sv */
interface ipv4p_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        ok;

  modport source (output valid, output address, output ok, input ready);
  modport sink (input valid, input address, input ok, output ready);
endinterface

/* hw/rtl/ipv4_dotted_text_parser.sv */
// IPv4 dotted-text parser (decimal forms a, a.b, a.b.c, a.b.c.d).
// Channel text: one transaction per byte, with character, has_character
// and last; has_character = 0 with last = 1 ends an empty text.
// Channel result: one transaction per text, after the byte marked last,
// with address (first octet in bits 31:24, zero on failure) and ok.
// Throughput: one byte per cycle. Each byte goes through an input
// register, then through the parse logic (the multiply-by-ten update)
// into the parse state and, for the last byte, into the result register.
// result.valid rises when the last byte moves into the result register.
// A stalled receiver holds the result register; bytes not marked last keep
// flowing, and a last byte waits in the input register until the result
// register frees, so text.ready drops only while a result is held and a
// further last byte is pending.
// Reset (rst, synchronous) empties both registers and clears the parse
// state; the state also clears after every completed text.
module ipv4_dotted_text_parser (
  input  logic        clk,
  input  logic        rst,
  ipv4p_in_if.sink    text,
  ipv4p_out_if.source result
);
  import ipv4p_pkg::*;

  ipv4p_item_t   item;
  logic          item_valid;
  logic          advance;
  logic          out_free;
  ipv4p_result_t res;

  // Move the held byte on unless it needs a result slot that is busy
  assign advance = item_valid && (!item.last || out_free);

  ipv4p_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  ipv4p_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item),
    .res  (res)
  );

  ipv4p_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && item.last),
    .res      (res),
    .out_free (out_free),
    .result   (result)
  );

  // A failed text reports a zero address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ok |-> result.address == 32'd0)
    else $error("failed result with nonzero address");

  // Input backpressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !text.ready |-> result.valid && !result.ready)
    else $error("input stalled without output stall");

  // A new result follows a last byte leaving the input register
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(advance && item.last))
    else $error("result without last byte");
endmodule

/* hw/rtl/ipv4p_in_stage.sv */
module ipv4p_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  ipv4p_in_if.sink             text,
  input  logic                 advance,
  output ipv4p_pkg::ipv4p_item_t item,
  output logic                 item_valid
);
  import ipv4p_pkg::*;

  logic take;

  // Accept whenever the register is empty or drains this cycle
  assign text.ready = !item_valid || advance;
  assign take       = text.valid && text.ready;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (take) begin
      item.character     <= text.character;
      item.has_character <= text.has_character;
      item.last          <= text.last;
    end
  end
endmodule

/* hw/rtl/ipv4p_parse.sv */
module ipv4p_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  ipv4p_pkg::ipv4p_item_t item,
  output ipv4p_pkg::ipv4p_result_t res
);
  import ipv4p_pkg::*;

  logic [31:0] acc;
  logic [7:0]  octets [NUM_STORED];
  logic [1:0]  pos;
  logic        failed;

  logic [31:0] acc_next;
  logic [7:0]  octets_next [NUM_STORED];
  logic [1:0]  pos_next;
  logic        failed_next;

  logic        is_digit;
  logic        is_dot;
  logic [35:0] prod;
  logic        fits;
  logic [31:0] head;

  // Classify the byte and form acc * 10 + digit
  assign is_digit = (item.character >= CHAR_ZERO) && (item.character <= CHAR_NINE);
  assign is_dot   = (item.character == CHAR_DOT);
  assign prod     = ({4'd0, acc} << 3) + ({4'd0, acc} << 1)
                  + {28'd0, item.character - CHAR_ZERO};

  // Apply one byte to the parse state
  always_comb begin
    acc_next    = acc;
    octets_next = octets;
    pos_next    = pos;
    failed_next = failed;
    if (item.has_character && !failed) begin
      if (is_digit) begin
        if (prod[35:32] != 4'd0) begin
          failed_next = 1'b1;
        end else begin
          acc_next = prod[31:0];
        end
      end else if (is_dot) begin
        if ((acc > OCTET_MAX) || (pos == POS_LAST)) begin
          failed_next = 1'b1;
        end else begin
          for (int i = 0; i < NUM_STORED; i++) begin
            if (pos == 2'(i)) begin
              octets_next[i] = acc[7:0];
            end
          end
          acc_next = '0;
          pos_next = pos + 2'd1;
        end
      end else begin
        failed_next = 1'b1;
      end
    end
  end

  // Check the final part against the octets left and assemble
  always_comb begin
    case (pos_next)
      2'd0:    fits = 1'b1;
      2'd1:    fits = (acc_next[31:24] == 8'd0);
      2'd2:    fits = (acc_next[31:16] == 16'd0);
      2'd3:    fits = (acc_next[31:8] == 24'd0);
      default: fits = 1'b0;
    endcase
    // Unused octet slots are always zero, so no masking by position
    head       = {octets_next[0], octets_next[1], octets_next[2], 8'd0};
    res.ok      = !failed_next && fits;
    res.address = res.ok ? (head | acc_next) : '0;
  end

  // Advance state; clear it after the last byte of a text
  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      acc    <= '0;
      octets <= '{default: '0};
      pos    <= '0;
      failed <= 1'b0;
    end else if (step) begin
      acc    <= acc_next;
      octets <= octets_next;
      pos    <= pos_next;
      failed <= failed_next;
    end
  end
endmodule

/* hw/rtl/ipv4p_out_stage.sv */
module ipv4p_out_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  ipv4p_pkg::ipv4p_result_t res,
  output logic                     out_free,
  ipv4p_out_if.source              result
);
  import ipv4p_pkg::*;

  ipv4p_result_t held;

  assign out_free       = !result.valid || result.ready;
  assign result.address = held.address;
  assign result.ok      = held.ok;

  // Hold valid until the receiver takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end
endmodule
